// ===== rtl/drcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcs_pkg: shared types and constants of the current sensor select unit
// Register map, channel status codes, queue entry format and limits.
// ----------------------------------------------------------------------------
package drcs_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CUR_W    = 24;
  localparam int unsigned MAG_W    = 23;
  localparam int unsigned SENS_W   = 24;

  localparam int unsigned FINE_SENS_Q16   = 65536;
  localparam int unsigned COARSE_SENS_Q16 = 655360;

  localparam logic signed [CUR_W-1:0] CUR_MAX = 24'sh7FFFFF;
  localparam logic signed [CUR_W-1:0] CUR_MIN = 24'sh800000;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // reset values of the configuration registers
  localparam logic [SAMPLE_W-1:0] RST_SAMPLE_MIN = 12'd0;
  localparam logic [SAMPLE_W-1:0] RST_SAMPLE_MAX = 12'd4095;
  localparam logic [SAMPLE_W-1:0] RST_ZERO_OFFS  = 12'd2048;
  localparam logic [MAG_W-1:0]    RST_FINE_SAT   = 23'd8388607;
  localparam logic [MAG_W-1:0]    RST_DEADZONE   = 23'd0;

  typedef enum logic [2:0] {
    REG_FINE_MIN     = 3'd0,
    REG_FINE_MAX     = 3'd1,
    REG_COARSE_MIN   = 3'd2,
    REG_COARSE_MAX   = 3'd3,
    REG_FINE_OFFS    = 3'd4,
    REG_COARSE_OFFS  = 3'd5,
    REG_FINE_SAT     = 3'd6,
    REG_DEADZONE     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_VALID          = 2'd0,
    ST_SAMPLE_INVALID = 2'd1,
    ST_CONFIG_INVALID = 2'd2
  } status_t;

  // what the back end does with a classified sample
  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,  // channel window misconfigured: no state change
    ACT_DROP = 2'd1,  // sample outside window: channel invalid, current zeroed
    ACT_LOAD = 2'd2   // valid sample: store current and reselect
  } act_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] fine_min;
    logic [SAMPLE_W-1:0] fine_max;
    logic [SAMPLE_W-1:0] coarse_min;
    logic [SAMPLE_W-1:0] coarse_max;
    logic [SAMPLE_W-1:0] fine_offs;
    logic [SAMPLE_W-1:0] coarse_offs;
    logic [MAG_W-1:0]    fine_sat;
    logic [MAG_W-1:0]    deadzone;
  } cfg_t;

  typedef struct packed {
    logic                    coarse;
    act_t                    act;
    logic signed [CUR_W-1:0] cur;
    logic                    clip;
  } entry_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/drcs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcs_cfg: APB register file
// Eight window, offset and threshold registers at 4-byte stride.
// ----------------------------------------------------------------------------
module drcs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [drcs_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [drcs_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [drcs_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output drcs_pkg::cfg_t                      cfg_o
);

  drcs_pkg::cfg_t     cfg_r;
  drcs_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx        = drcs_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine_min    <= drcs_pkg::RST_SAMPLE_MIN;
      cfg_r.fine_max    <= drcs_pkg::RST_SAMPLE_MAX;
      cfg_r.coarse_min  <= drcs_pkg::RST_SAMPLE_MIN;
      cfg_r.coarse_max  <= drcs_pkg::RST_SAMPLE_MAX;
      cfg_r.fine_offs   <= drcs_pkg::RST_ZERO_OFFS;
      cfg_r.coarse_offs <= drcs_pkg::RST_ZERO_OFFS;
      cfg_r.fine_sat    <= drcs_pkg::RST_FINE_SAT;
      cfg_r.deadzone    <= drcs_pkg::RST_DEADZONE;
    end else if (wr_en) begin
      case (idx)
        drcs_pkg::REG_FINE_MIN:    cfg_r.fine_min    <= cfg_pwdata[11:0];
        drcs_pkg::REG_FINE_MAX:    cfg_r.fine_max    <= cfg_pwdata[11:0];
        drcs_pkg::REG_COARSE_MIN:  cfg_r.coarse_min  <= cfg_pwdata[11:0];
        drcs_pkg::REG_COARSE_MAX:  cfg_r.coarse_max  <= cfg_pwdata[11:0];
        drcs_pkg::REG_FINE_OFFS:   cfg_r.fine_offs   <= cfg_pwdata[11:0];
        drcs_pkg::REG_COARSE_OFFS: cfg_r.coarse_offs <= cfg_pwdata[11:0];
        drcs_pkg::REG_FINE_SAT:    cfg_r.fine_sat    <= cfg_pwdata[22:0];
        drcs_pkg::REG_DEADZONE:    cfg_r.deadzone    <= cfg_pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      drcs_pkg::REG_FINE_MIN:    cfg_prdata = {20'd0, cfg_r.fine_min};
      drcs_pkg::REG_FINE_MAX:    cfg_prdata = {20'd0, cfg_r.fine_max};
      drcs_pkg::REG_COARSE_MIN:  cfg_prdata = {20'd0, cfg_r.coarse_min};
      drcs_pkg::REG_COARSE_MAX:  cfg_prdata = {20'd0, cfg_r.coarse_max};
      drcs_pkg::REG_FINE_OFFS:   cfg_prdata = {20'd0, cfg_r.fine_offs};
      drcs_pkg::REG_COARSE_OFFS: cfg_prdata = {20'd0, cfg_r.coarse_offs};
      drcs_pkg::REG_FINE_SAT:    cfg_prdata = {9'd0, cfg_r.fine_sat};
      drcs_pkg::REG_DEADZONE:    cfg_prdata = {9'd0, cfg_r.deadzone};
      default:                   cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/drcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcs_front: sample classification and scaling
// Checks the channel window, then scales (sample - offset) by the channel
// sensitivity, rounds to mA and saturates to 24 bits.
// ----------------------------------------------------------------------------
module drcs_front #(
  parameter int unsigned FINE_SENS   = drcs_pkg::FINE_SENS_Q16,
  parameter int unsigned COARSE_SENS = drcs_pkg::COARSE_SENS_Q16
) (
  input  logic                              coarse_i,
  input  logic [drcs_pkg::SAMPLE_W-1:0]     sample_i,
  input  drcs_pkg::cfg_t                    cfg_i,
  output drcs_pkg::entry_t                  entry_o
);

  localparam int unsigned DIFF_W = drcs_pkg::SAMPLE_W + 1;
  localparam int unsigned K_W    = drcs_pkg::SENS_W + 1;
  localparam int unsigned PROD_W = DIFF_W + K_W;

  localparam logic signed [K_W-1:0] FINE_K   = K_W'(FINE_SENS);
  localparam logic signed [K_W-1:0] COARSE_K = K_W'(COARSE_SENS);

  logic [drcs_pkg::SAMPLE_W-1:0] mn, mx, offs;
  logic signed [K_W-1:0]         k;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W-1:0]      prod, rnd, q;
  logic                          cfg_ok, in_win, clip_hi, clip_lo;

  always_comb begin
    mn   = coarse_i ? cfg_i.coarse_min  : cfg_i.fine_min;
    mx   = coarse_i ? cfg_i.coarse_max  : cfg_i.fine_max;
    offs = coarse_i ? cfg_i.coarse_offs : cfg_i.fine_offs;
    k    = coarse_i ? COARSE_K : FINE_K;

    diff = $signed({1'b0, sample_i}) - $signed({1'b0, offs});
    prod = PROD_W'(diff) * PROD_W'(k);
    // round half up, then floor by 2^16
    rnd  = prod + PROD_W'(32768);
    q    = rnd >>> 16;

    clip_hi = q > PROD_W'(drcs_pkg::CUR_MAX);
    clip_lo = q < PROD_W'(drcs_pkg::CUR_MIN);

    cfg_ok = mn < mx;
    in_win = (sample_i >= mn) && (sample_i <= mx);

    entry_o.coarse = coarse_i;
    if (!cfg_ok) begin
      entry_o.act = drcs_pkg::ACT_HOLD;
    end else if (!in_win) begin
      entry_o.act = drcs_pkg::ACT_DROP;
    end else begin
      entry_o.act = drcs_pkg::ACT_LOAD;
    end
    if (clip_hi) begin
      entry_o.cur = drcs_pkg::CUR_MAX;
    end else if (clip_lo) begin
      entry_o.cur = drcs_pkg::CUR_MIN;
    end else begin
      entry_o.cur = q[drcs_pkg::CUR_W-1:0];
    end
    entry_o.clip = (clip_hi | clip_lo) & cfg_ok & in_win;
  end

endmodule

// ===== rtl/drcs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcs_fifo: short queue between front and back end
// Flop-based, two entries; ready while not full.
// ----------------------------------------------------------------------------
module drcs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  drcs_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             nempty_o,
  output drcs_pkg::entry_t rdata_o
);

  drcs_pkg::entry_t                mem_r [drcs_pkg::QUEUE_DEPTH];
  logic [drcs_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [drcs_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full_o   = cnt_r == drcs_pkg::QCNT_W'(drcs_pkg::QUEUE_DEPTH);
  assign nempty_o = cnt_r != '0;
  assign rdata_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == drcs_pkg::QPTR_W'(drcs_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == drcs_pkg::QPTR_W'(drcs_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

endmodule

// ===== rtl/drcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcs_back: channel state, range selection and result register
// Applies one queued sample per cycle while the result beat is not stalled,
// reselects the sensor current and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module drcs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  drcs_pkg::cfg_t                    cfg_i,
  input  logic                              q_nempty_i,
  input  drcs_pkg::entry_t                  q_entry_i,
  output logic                              q_pop_o,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata
);

  localparam int unsigned CW = drcs_pkg::CUR_W;
  localparam int unsigned EW = CW + 1;

  logic signed [CW-1:0] fine_cur_r, fine_cur_nxt, coarse_cur_r, coarse_cur_nxt;
  logic signed [CW-1:0] sensor_r, sensor_nxt, sel;
  logic                 fine_valid_r, fine_valid_nxt, coarse_valid_r, coarse_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_data_r, out_data_nxt;
  logic signed [EW-1:0] fine_e, sel_e, sat_e, dz_e;
  logic                 reselect;
  drcs_pkg::status_t    fine_st, coarse_st;

  assign q_pop_o    = q_nempty_i & (~out_valid_r | out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    fine_cur_nxt     = fine_cur_r;
    coarse_cur_nxt   = coarse_cur_r;
    fine_valid_nxt   = fine_valid_r;
    coarse_valid_nxt = coarse_valid_r;
    reselect         = 1'b0;

    case (q_entry_i.act)
      drcs_pkg::ACT_DROP: begin
        if (q_entry_i.coarse) begin
          coarse_valid_nxt = 1'b0;
          coarse_cur_nxt   = '0;
        end else begin
          fine_valid_nxt = 1'b0;
          fine_cur_nxt   = '0;
        end
      end
      drcs_pkg::ACT_LOAD: begin
        reselect = 1'b1;
        if (q_entry_i.coarse) begin
          coarse_valid_nxt = 1'b1;
          coarse_cur_nxt   = q_entry_i.cur;
        end else begin
          fine_valid_nxt = 1'b1;
          fine_cur_nxt   = q_entry_i.cur;
        end
      end
      default: ;
    endcase

    // fine range unless it lies outside +/- saturation
    fine_e = EW'(fine_cur_nxt);
    sat_e  = $signed({2'b00, cfg_i.fine_sat});
    dz_e   = $signed({2'b00, cfg_i.deadzone});
    sel    = (fine_e > sat_e || fine_e < -sat_e) ? coarse_cur_nxt : fine_cur_nxt;
    sel_e  = EW'(sel);
    if (sel_e < dz_e && sel_e > -dz_e) begin
      sel = '0;
    end
    sensor_nxt = reselect ? sel : sensor_r;

    if (cfg_i.fine_min >= cfg_i.fine_max) begin
      fine_st = drcs_pkg::ST_CONFIG_INVALID;
    end else begin
      fine_st = fine_valid_nxt ? drcs_pkg::ST_VALID : drcs_pkg::ST_SAMPLE_INVALID;
    end
    if (cfg_i.coarse_min >= cfg_i.coarse_max) begin
      coarse_st = drcs_pkg::ST_CONFIG_INVALID;
    end else begin
      coarse_st = coarse_valid_nxt ? drcs_pkg::ST_VALID : drcs_pkg::ST_SAMPLE_INVALID;
    end

    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    if (q_pop_o) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'd0, q_entry_i.clip, coarse_st, fine_st, sensor_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_cur_r     <= '0;
      coarse_cur_r   <= '0;
      sensor_r       <= '0;
      fine_valid_r   <= 1'b0;
      coarse_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop_o) begin
        fine_cur_r     <= fine_cur_nxt;
        coarse_cur_r   <= coarse_cur_nxt;
        sensor_r       <= sensor_nxt;
        fine_valid_r   <= fine_valid_nxt;
        coarse_valid_r <= coarse_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/dual_range_current_sensor_select_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_range_current_sensor_select_unit: dual-range current sensor select
// Scales fine/coarse ADC samples to mA and selects the sensor current.
// ----------------------------------------------------------------------------
//   port group | dir | beat contents
//   in_*       | in  | tuser: channel_sel; tdata: adc_sample
//   out_*      | out | tdata: current_ma, fine/coarse status, clipped
//   cfg_*      | in  | APB writes/reads of the eight registers
//
// One sample per clock sustained while out_tready stays high; each result beat
// is registered in the queue and then in the result register. The front end
// classifies and scales (one multiplier) in the accepting cycle; the back end
// updates state from the queue head (a two-entry queue) when it can pop.
// Reset is synchronous; channel state and config registers return to defaults.
// in_tready drops only while the queue is full because out_tready is low.
// ----------------------------------------------------------------------------
module dual_range_current_sensor_select_unit #(
  parameter int unsigned FINE_SENS   = drcs_pkg::FINE_SENS_Q16,
  parameter int unsigned COARSE_SENS = drcs_pkg::COARSE_SENS_Q16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [11:0] adc_sample
  input  logic                            in_tuser,   // [0] channel_sel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [23:0] current_ma, [25:24] fine_status, [27:26] coarse_status, [28] clipped
  output logic [31:0]                     out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [drcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [drcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [drcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  drcs_pkg::cfg_t   cfg;
  drcs_pkg::entry_t f_entry, q_entry;
  logic             q_full, q_nempty, q_pop, push;

  assign in_tready = ~q_full;
  assign push      = in_tvalid & in_tready;

  drcs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  drcs_front #(
    .FINE_SENS   (FINE_SENS),
    .COARSE_SENS (COARSE_SENS)
  ) u_front (
    .coarse_i (in_tuser),
    .sample_i (in_tdata[11:0]),
    .cfg_i    (cfg),
    .entry_o  (f_entry)
  );

  drcs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .wdata_i  (f_entry),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .nempty_o (q_nempty),
    .rdata_o  (q_entry)
  );

  drcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .q_nempty_i (q_nempty),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/drcs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcs_chk: port-level checks of the current sensor select unit
// Watches result beats and reset behaviour; bound to the top level.
// ----------------------------------------------------------------------------
module drcs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // no result straight after reset
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // status fields only carry defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[25:24] <= drcs_pkg::ST_CONFIG_INVALID) &&
                   (out_tdata[27:26] <= drcs_pkg::ST_CONFIG_INVALID))
    else $error("undefined channel status");

  // a clipped current comes from a sample that made its channel valid
  a_clip_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[28] |->
      (out_tdata[25:24] == drcs_pkg::ST_VALID) || (out_tdata[27:26] == drcs_pkg::ST_VALID))
    else $error("clip flagged without a valid channel");

endmodule

bind dual_range_current_sensor_select_unit drcs_chk u_drcs_chk (.*);

// ===== test/tb_dual_range_current_sensor_select_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_range_current_sensor_select_unit: self-checking bench
// Drives ADC sample beats on the input stream and programs the window, offset,
// saturation and deadzone registers over APB between phases. A behavioural
// model of both channels predicts each untyped result beat; the monitor compares
// each beat field by field with the oldest prediction. A directed table comes
// first, then randomised phases with random back-pressure and source gaps.
// ----------------------------------------------------------------------------
module tb_dual_range_current_sensor_select_unit;
  import drcs_pkg::*;

  localparam int  RAND_PHASES = 8;
  localparam int  PHASE_ITEMS = 250;
  localparam int  PLAN_ROWS   = 38;
  localparam logic CH_FINE    = 1'b0;
  localparam logic CH_COARSE  = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one row: a sample beat (chan, val) or a register write (idx, val);
  // typed rows carry their expected result beat
  typedef struct packed {
    row_kind_t               kind;
    logic                    chan;
    logic [MAG_W-1:0]        val;
    reg_idx_t                idx;
    logic                    typed;
    logic signed [CUR_W-1:0] cur;
    status_t                 fs;
    status_t                 cs;
    logic                    clip;
  } plan_row_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] cur;
    status_t                 fs;
    status_t                 cs;
    logic                    clip;
  } reading_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [11:0] adc_sample
  logic                  in_tuser;   // [0] channel_sel
  logic                  out_tvalid;
  logic                  out_tready;
  // [23:0] current_ma, [25:24] fine_status, [27:26] coarse_status, [28] clipped
  logic [31:0]           out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // shadow registers and channel state of the model
  logic [SAMPLE_W-1:0] fine_lo, fine_hi, coarse_lo, coarse_hi, fine_zero, coarse_zero;
  int                  fine_sat_ma, dead_ma;
  int                  fine_ma, coarse_ma, sensor_ma;
  bit                  fine_ok, coarse_ok;

  reading_t pending_readings[$];
  int       fail_count;
  int       sender_gap_pct;
  int       sink_stall_pct;

  plan_row_t plan [PLAN_ROWS] = '{
    // defaults: window full, offsets mid-scale, no saturation, no deadzone
    '{ROW_ITEM, CH_FINE,   23'd2048, REG_FINE_MIN, 1'b1, 24'sd0, ST_VALID, ST_SAMPLE_INVALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd4095, REG_FINE_MIN, 1'b1, 24'sd2047, ST_VALID, ST_SAMPLE_INVALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd0,    REG_FINE_MIN, 1'b1, -24'sd2048, ST_VALID, ST_SAMPLE_INVALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd0,    REG_FINE_MIN, 1'b1, -24'sd2048, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd4095, REG_FINE_MIN, 1'b1, -24'sd2048, ST_VALID, ST_VALID, 1'b0},
    // fine channel saturates, coarse takes over
    '{ROW_CFG,  CH_FINE,   23'd100,  REG_FINE_SAT, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd0,    REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'h7FFFFF, REG_DEADZONE, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd2100, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'd0,    REG_DEADZONE, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    // narrow fine window, samples just outside and on the edges
    '{ROW_CFG,  CH_FINE,   23'd1000, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'd3000, REG_FINE_MAX, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd999,  REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd3001, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd1000, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd3000, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    // min equal to max: fine channel misconfigured, partner sees stale fine value
    '{ROW_CFG,  CH_FINE,   23'h7FFFFF, REG_FINE_SAT, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'd3000, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd2048, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd1000, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'd3500, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd0,    REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    // window repaired: old valid bit and current kept until the next fine beat
    '{ROW_CFG,  CH_FINE,   23'd0,    REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd3000, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd2048, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    // offset extremes, zero saturation threshold
    '{ROW_CFG,  CH_FINE,   23'd0,    REG_FINE_OFFS, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'd4095, REG_COARSE_OFFS, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'd0,    REG_FINE_SAT, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd3000, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd0,    REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_FINE,   23'd0,    REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    // coarse window inverted, then narrowed
    '{ROW_CFG,  CH_FINE,   23'd2000, REG_COARSE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'd1999, REG_COARSE_MAX, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd10,   REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_CFG,  CH_FINE,   23'd2500, REG_COARSE_MAX, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd1999, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd2501, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0},
    '{ROW_ITEM, CH_COARSE, 23'd2000, REG_FINE_MIN, 1'b0, 24'sd0, ST_VALID, ST_VALID, 1'b0}
  };

  dual_range_current_sensor_select_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] reg_mask(reg_idx_t idx);
    if (idx == REG_FINE_SAT || idx == REG_DEADZONE) return 32'h007F_FFFF;
    return 32'h0000_0FFF;
  endfunction

  function automatic logic [31:0] reset_setting(reg_idx_t idx);
    case (idx)
      REG_FINE_MIN, REG_COARSE_MIN:   return 32'(RST_SAMPLE_MIN);
      REG_FINE_MAX, REG_COARSE_MAX:   return 32'(RST_SAMPLE_MAX);
      REG_FINE_OFFS, REG_COARSE_OFFS: return 32'(RST_ZERO_OFFS);
      REG_FINE_SAT:                   return 32'(RST_FINE_SAT);
      default:                        return 32'(RST_DEADZONE);
    endcase
  endfunction

  function automatic void store_setting(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_FINE_MIN:    fine_lo     = v[SAMPLE_W-1:0];
      REG_FINE_MAX:    fine_hi     = v[SAMPLE_W-1:0];
      REG_COARSE_MIN:  coarse_lo   = v[SAMPLE_W-1:0];
      REG_COARSE_MAX:  coarse_hi   = v[SAMPLE_W-1:0];
      REG_FINE_OFFS:   fine_zero   = v[SAMPLE_W-1:0];
      REG_COARSE_OFFS: coarse_zero = v[SAMPLE_W-1:0];
      REG_FINE_SAT:    fine_sat_ma = int'(v[MAG_W-1:0]);
      REG_DEADZONE:    dead_ma     = int'(v[MAG_W-1:0]);
      default: ;
    endcase
  endfunction

  // (count - zero) * sens in Q16.16, round half up, saturate to 24 bits
  function automatic int scale_count(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] zero,
                                     longint sens, output bit clip);
    longint q;
    q = ((longint'(s) - longint'(zero)) * sens + 64'sd32768) >>> 16;
    clip = 1'b0;
    if (q > longint'(CUR_MAX)) begin
      clip = 1'b1;
      q = longint'(CUR_MAX);
    end else if (q < longint'(CUR_MIN)) begin
      clip = 1'b1;
      q = longint'(CUR_MIN);
    end
    return int'(q);
  endfunction

  function automatic void select_sensor();
    int v;
    if (fine_ma > fine_sat_ma || fine_ma < -fine_sat_ma) v = coarse_ma;
    else v = fine_ma;
    if (v < dead_ma && v > -dead_ma) v = 0;
    sensor_ma = v;
  endfunction

  function automatic status_t window_status(logic [SAMPLE_W-1:0] lo,
                                            logic [SAMPLE_W-1:0] hi, bit ok);
    if (lo >= hi) return ST_CONFIG_INVALID;
    return ok ? ST_VALID : ST_SAMPLE_INVALID;
  endfunction

  function automatic reading_t predict_reading(logic chan, logic [SAMPLE_W-1:0] s);
    reading_t r;
    bit       clip;
    clip = 1'b0;
    if (chan == CH_FINE) begin
      if (fine_lo < fine_hi) begin
        if (s < fine_lo || s > fine_hi) begin
          fine_ok = 1'b0;
          fine_ma = 0;
        end else begin
          fine_ok = 1'b1;
          fine_ma = scale_count(s, fine_zero, longint'(FINE_SENS_Q16), clip);
          select_sensor();
        end
      end
    end else begin
      if (coarse_lo < coarse_hi) begin
        if (s < coarse_lo || s > coarse_hi) begin
          coarse_ok = 1'b0;
          coarse_ma = 0;
        end else begin
          coarse_ok = 1'b1;
          coarse_ma = scale_count(s, coarse_zero, longint'(COARSE_SENS_Q16), clip);
          select_sensor();
        end
      end
    end
    r.cur  = sensor_ma[CUR_W-1:0];
    r.fs   = window_status(fine_lo, fine_hi, fine_ok);
    r.cs   = window_status(coarse_lo, coarse_hi, coarse_ok);
    r.clip = clip;
    return r;
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < 8; i++) store_setting(reg_idx_t'(i), reset_setting(reg_idx_t'(i)));
    fine_ma   = 0;
    coarse_ma = 0;
    sensor_ma = 0;
    fine_ok   = 1'b0;
    coarse_ok = 1'b0;
  endfunction

  // mostly inside the channel window, some edges, extremes and strays
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic chan);
    logic [SAMPLE_W-1:0] lo, hi;
    int                  r;
    lo = (chan == CH_FINE) ? fine_lo : coarse_lo;
    hi = (chan == CH_FINE) ? fine_hi : coarse_hi;
    r  = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 3 || lo >= hi) return SAMPLE_W'($urandom_range(0, 4095));
    if (r == 4) return lo;
    if (r == 5) return hi;
    return SAMPLE_W'($urandom_range(int'(lo), int'(hi)));
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd4095;
      default: return 32'($urandom_range(0, 4095));
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // write one register, then read it back
  task automatic write_setting(reg_idx_t idx, logic [31:0] value);
    logic [31:0] keep, wdata;
    keep  = reg_mask(idx);
    wdata = ($urandom & ~keep) | (value & keep);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    store_setting(idx, wdata);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== (wdata & keep)) begin
      $error("prdata reg %0d: expected %0h, actual %0h", idx, wdata & keep, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic write_window(reg_idx_t lo_reg, reg_idx_t hi_reg);
    int r, lo, hi;
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      lo = 0;
      hi = 4095;
    end else if (r <= 8) begin
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(2048, 4095);
    end else begin
      // min not below max
      lo = $urandom_range(1, 4095);
      hi = $urandom_range(0, lo);
    end
    write_setting(lo_reg, 32'(lo));
    write_setting(hi_reg, 32'(hi));
  endtask

  task automatic pick_settings();
    logic [31:0] sat, dz;
    case ($urandom_range(0, 4))
      0:       sat = 32'h7F_FFFF;
      1:       sat = 32'd0;
      2:       sat = 32'($urandom_range(0, 8388607));
      default: sat = 32'($urandom_range(0, 2500));
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: dz = 32'd0;
      7:          dz = 32'($urandom_range(0, 8388607));
      default:    dz = 32'($urandom_range(0, 300));
    endcase
    write_window(REG_FINE_MIN, REG_FINE_MAX);
    write_window(REG_COARSE_MIN, REG_COARSE_MAX);
    write_setting(REG_FINE_OFFS, pick_offset());
    write_setting(REG_COARSE_OFFS, pick_offset());
    write_setting(REG_FINE_SAT, sat);
    write_setting(REG_DEADZONE, dz);
  endtask

  // hold the source off until every predicted beat has come back
  task automatic drain_readings();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic send_sample(logic chan, logic [SAMPLE_W-1:0] s, bit typed, reading_t fixed);
    reading_t got;
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = chan;
    in_tdata  = {4'b0000, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = predict_reading(chan, s);
    pending_readings.push_back(typed ? fixed : got);
  endtask

  // sink back-pressure in bursts
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (rst_n && $urandom_range(0, 99) < sink_stall_pct) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $error("result beat %0h with no expectation waiting", out_tdata);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[23:0] !== want.cur) begin
          $error("current_ma: expected %0d, actual %0d", want.cur, $signed(out_tdata[23:0]));
          fail_count++;
        end
        if (out_tdata[25:24] !== want.fs) begin
          $error("fine_status: expected %0d, actual %0d", want.fs, out_tdata[25:24]);
          fail_count++;
        end
        if (out_tdata[27:26] !== want.cs) begin
          $error("coarse_status: expected %0d, actual %0d", want.cs, out_tdata[27:26]);
          fail_count++;
        end
        if (out_tdata[28] !== want.clip) begin
          $error("clipped: expected %0d, actual %0d", want.clip, out_tdata[28]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int                  i, ph, n;
    logic                chan;
    logic [SAMPLE_W-1:0] s;
    reading_t            fixed;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    fail_count     = 0;
    sender_gap_pct = 25;
    sink_stall_pct = 20;
    reset_shadow();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_readings();
        write_setting(plan[i].idx, 32'(plan[i].val));
      end else begin
        fixed.cur  = plan[i].cur;
        fixed.fs   = plan[i].fs;
        fixed.cs   = plan[i].cs;
        fixed.clip = plan[i].clip;
        send_sample(plan[i].chan, plan[i].val[SAMPLE_W-1:0], plan[i].typed, fixed);
      end
    end

    drain_readings();
    for (i = 0; i < 8; i++) write_setting(reg_idx_t'(i), reset_setting(reg_idx_t'(i)));

    fixed = '0;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain_readings();
      pick_settings();
      if (ph == RAND_PHASES - 1 || $urandom_range(0, 3) == 0) begin
        sender_gap_pct = 0;
        sink_stall_pct = 0;
      end else begin
        sender_gap_pct = $urandom_range(10, 40);
        sink_stall_pct = $urandom_range(10, 40);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) drain_readings();
        chan = 1'($urandom_range(0, 1));
        s    = pick_sample(chan);
        send_sample(chan, s, 1'b0, fixed);
      end
    end

    drain_readings();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout: %0d result beats still outstanding", pending_readings.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
